FILE: rtl/core/integer_text_formatter_macros.svh
// Assertion macros used by the integer text formatter top level.
`ifndef INTEGER_TEXT_FORMATTER_MACROS_SVH
`define INTEGER_TEXT_FORMATTER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define ITF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer_text_formatter assertion failed");
// Next-cycle implication, checked outside reset.
`define ITF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer_text_formatter assertion failed");
`else
`define ITF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ITF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/itf_pkg.sv
// Shared types, constants and functions of the integer text formatter.
package itf_pkg;

  // Decimal digits of a 64-bit value, BCD register width
  localparam int NUM_DIGITS = 20;
  localparam int DIG_W      = 4 * NUM_DIGITS;
  localparam int VALUE_W    = 64;
  localparam int STEP_W     = 6;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);
  localparam logic [4:0] DIGITS_INIT = 5'(NUM_DIGITS);

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_PREP,
    ST_PAD_PRE,
    ST_SIGN,
    ST_DIGIT,
    ST_PAD_POST
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic scan_shift;
    logic prep;
    logic emit_pad;
    logic emit_sign;
    logic emit_digit;
    logic emit_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hex;
    logic neg;
    logic left;
    logic lead_zero;
    logic pad_none;
    logic pad_one;
    logic dig_one;
    logic out_free;
  } status_t;

  // ASCII for one digit, 0..15
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CHAR_UP_A : CHAR_LOW_A;
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d - 4'd10};
    end
  endfunction

endpackage

FILE: rtl/core/itf_datapath.sv
// Datapath: double-dabble conversion, digit scan, counters and output register.
module itf_datapath #(
  parameter int MAX_WIDTH = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [63:0]         in_value,
  input  logic                in_hex_mode,
  input  logic                in_upper_case,
  input  logic signed [6:0]   in_field_width,
  input  logic                in_negative,
  input  logic [7:0]          in_pad_char,
  input  itf_pkg::cmd_t       cmd,
  output itf_pkg::status_t    st,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                out_last,
  output logic [5:0]          out_printed_length
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [itf_pkg::VALUE_W-1:0] bin_r;
  logic [itf_pkg::DIG_W-1:0]   dig_r, dig_adj;
  logic [4:0]                  dig_cnt_r;
  logic                        hex_r, upper_r, neg_r, left_r;
  logic [7:0]                  pad_r;
  logic [WW-1:0]               width_r, pad_cnt_r, total_r;
  logic                        out_valid_r;
  logic [7:0]                  out_char_r;
  logic                        out_last_r;
  logic [5:0]                  out_len_r;

  logic [6:0]    wmag, wsat;
  logic [4:0]    cnt;
  logic [WW-1:0] cnt_w;
  logic [7:0]    char_nxt;
  logic          emit;

  // Field width magnitude, saturated
  always_comb begin
    wmag = in_field_width[6] ? (7'd0 - $unsigned(in_field_width)) : $unsigned(in_field_width);
    wsat = (wmag > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : wmag;
  end

  // Add-3 adjust of every BCD digit ahead of the shift
  always_comb begin
    logic [3:0] d;
    d = 4'd0;
    dig_adj = '0;
    for (int i = 0; i < itf_pkg::NUM_DIGITS; i++) begin
      d = dig_r[4*i +: 4];
      dig_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  // Printed text length without padding
  assign cnt   = dig_cnt_r + {4'd0, neg_r};
  assign cnt_w = WW'(cnt);

  // Character for the current emission
  always_comb begin
    priority if (cmd.emit_digit) begin
      char_nxt = itf_pkg::digit_char(dig_r[itf_pkg::DIG_W-1 -: 4], upper_r);
    end else if (cmd.emit_sign) begin
      char_nxt = itf_pkg::CHAR_MINUS;
    end else begin
      char_nxt = pad_r;
    end
  end

  assign emit = cmd.emit_pad | cmd.emit_sign | cmd.emit_digit;

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hex_r     <= in_hex_mode;
      upper_r   <= in_upper_case;
      neg_r     <= in_negative;
      left_r    <= in_field_width[6];
      pad_r     <= in_pad_char;
      width_r   <= WW'(wsat);
      bin_r     <= in_value;
      dig_cnt_r <= itf_pkg::DIGITS_INIT;
      dig_r     <= in_hex_mode ? itf_pkg::DIG_W'(in_value) : '0;
    end else if (cmd.conv_step) begin
      dig_r <= {dig_adj[itf_pkg::DIG_W-2:0], bin_r[itf_pkg::VALUE_W-1]};
      bin_r <= {bin_r[itf_pkg::VALUE_W-2:0], 1'b0};
    end else if (cmd.scan_shift || cmd.emit_digit) begin
      dig_r     <= {dig_r[itf_pkg::DIG_W-5:0], 4'd0};
      dig_cnt_r <= dig_cnt_r - 5'd1;
    end
    if (cmd.prep) begin
      pad_cnt_r <= (width_r > cnt_w) ? width_r - cnt_w : '0;
      total_r   <= (width_r > cnt_w) ? width_r : cnt_w;
    end else if (cmd.emit_pad) begin
      pad_cnt_r <= pad_cnt_r - WW'(1);
    end
    if (emit) begin
      out_char_r <= char_nxt;
      out_last_r <= cmd.emit_last;
      out_len_r  <= cmd.emit_last ? 6'(total_r) : 6'd0;
    end
  end

  // Output item valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Status to the controller
  always_comb begin
    st.hex       = hex_r;
    st.neg       = neg_r;
    st.left      = left_r;
    st.lead_zero = (dig_r[itf_pkg::DIG_W-1 -: 4] == 4'd0) && (dig_cnt_r > 5'd1);
    st.pad_none  = (pad_cnt_r == '0);
    st.pad_one   = (pad_cnt_r == WW'(1));
    st.dig_one   = (dig_cnt_r == 5'd1);
    st.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_char           = out_char_r;
  assign out_last           = out_last_r;
  assign out_printed_length = out_len_r;

endmodule

FILE: rtl/core/itf_ctrl.sv
// Controller: sequences conversion, leading-zero scan and character emission.
module itf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  itf_pkg::status_t  st,
  output itf_pkg::cmd_t     cmd
);

  itf_pkg::state_t             state_r, state_nxt;
  logic [itf_pkg::STEP_W-1:0]  step_r, step_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itf_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      itf_pkg::ST_IDLE: begin
        // no item is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = itf_pkg::ST_CONV;
        end
      end
      itf_pkg::ST_CONV: begin
        // hex digits are loaded directly, decimal takes one step per bit
        if (st.hex) begin
          state_nxt = itf_pkg::ST_SCAN;
        end else begin
          cmd.conv_step = 1'b1;
          step_nxt      = step_r + 1'b1;
          if (step_r == itf_pkg::LAST_STEP) begin
            state_nxt = itf_pkg::ST_SCAN;
          end
        end
      end
      itf_pkg::ST_SCAN: begin
        if (st.lead_zero) begin
          cmd.scan_shift = 1'b1;
        end else begin
          state_nxt = itf_pkg::ST_PREP;
        end
      end
      itf_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
        if (!st.left) begin
          state_nxt = itf_pkg::ST_PAD_PRE;
        end else if (st.neg) begin
          state_nxt = itf_pkg::ST_SIGN;
        end else begin
          state_nxt = itf_pkg::ST_DIGIT;
        end
      end
      itf_pkg::ST_PAD_PRE: begin
        if (st.pad_none) begin
          state_nxt = st.neg ? itf_pkg::ST_SIGN : itf_pkg::ST_DIGIT;
        end else if (st.out_free) begin
          cmd.emit_pad = 1'b1;
          if (st.pad_one) begin
            state_nxt = st.neg ? itf_pkg::ST_SIGN : itf_pkg::ST_DIGIT;
          end
        end
      end
      itf_pkg::ST_SIGN: begin
        if (st.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = itf_pkg::ST_DIGIT;
        end
      end
      itf_pkg::ST_DIGIT: begin
        if (st.out_free) begin
          cmd.emit_digit = 1'b1;
          cmd.emit_last  = st.dig_one && (!st.left || st.pad_none);
          if (st.dig_one) begin
            state_nxt = (st.left && !st.pad_none) ? itf_pkg::ST_PAD_POST : itf_pkg::ST_IDLE;
          end
        end
      end
      itf_pkg::ST_PAD_POST: begin
        if (st.out_free) begin
          cmd.emit_pad  = 1'b1;
          cmd.emit_last = st.pad_one;
          if (st.pad_one) begin
            state_nxt = itf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = itf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/integer_text_formatter.sv
// Top level of the integer text formatter: controller, datapath and checks.
//
// Input channel (in_valid/in_ready): one item is one number with its format:
// value, radix, letter case, signed field width, minus flag and pad character.
// Output channel (out_valid/out_ready): one item per ASCII character, most
// significant digit first, pads before or after the text; out_last marks the
// final character, which also carries out_printed_length.
// Steps per item: load; decimal conversion by shift-and-add-3 on a 20-digit
// BCD register, one step per input bit (hex skips it); leading-zero scan,
// which suppresses up to 19 zeros; setup; then one character per cycle while
// the receiver takes them. A right-justified field with no padding still
// passes through the pad state before its text.
// One number is in work at a time.
// in_ready is high only between numbers; the next number is taken while the
// final character still waits in the output register.
// A stalled receiver holds the output register and pauses emission.
// Reset (rst_n low, synchronous) empties the output and returns to idle.
`include "integer_text_formatter_macros.svh"

module integer_text_formatter #(
  parameter int MAX_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_value,
  input  logic               in_hex_mode,
  input  logic               in_upper_case,
  input  logic signed [6:0]  in_field_width,
  input  logic               in_negative,
  input  logic [7:0]         in_pad_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               out_last,
  output logic [5:0]         out_printed_length
);

  itf_pkg::cmd_t    cmd;
  itf_pkg::status_t st;
  logic             char_emit;

  itf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  itf_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_value           (in_value),
    .in_hex_mode        (in_hex_mode),
    .in_upper_case      (in_upper_case),
    .in_field_width     (in_field_width),
    .in_negative        (in_negative),
    .in_pad_char        (in_pad_char),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char           (out_char),
    .out_last           (out_last),
    .out_printed_length (out_printed_length)
  );

  assign char_emit = cmd.emit_pad || cmd.emit_sign || cmd.emit_digit;

  // Characters only go out when the output register can take them
  `ITF_ASSERT_IMPLIES(a_emit_has_room, clk, rst_n, char_emit, st.out_free)
  // At most one character source per cycle
  `ITF_ASSERT_IMPLIES(a_one_source, clk, rst_n, 1'b1, $onehot0({cmd.emit_pad, cmd.emit_sign, cmd.emit_digit}))
  // An accepted number keeps the block busy
  `ITF_ASSERT_NEXT(a_busy_after_load, clk, rst_n, in_valid && in_ready, !in_ready)
  // Length is reported on the final character only
  `ITF_ASSERT_IMPLIES(a_len_on_last, clk, rst_n, out_valid && !out_last, out_printed_length == 6'd0)

endmodule

FILE: sim/integer_text_formatter_checker.sv
// Scoreboard for the integer text formatter: predicts each number's text and checks it.
`timescale 1ns / 1ps

module integer_text_formatter_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [63:0]       in_value,
  input  logic              in_hex_mode,
  input  logic              in_upper_case,
  input  logic signed [6:0] in_field_width,
  input  logic              in_negative,
  input  logic [7:0]        in_pad_char,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_char,
  input  logic              out_last,
  input  logic [5:0]        out_printed_length,
  output int                mismatch_count,
  output int                chars_outstanding
);

  localparam int         MAX_WIDTH  = 48;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam int         REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [5:0] length;
  } text_char_t;

  // Characters still owed by the block, oldest first
  text_char_t expected_text[$];
  int errors = 0;
  int owed = 0;

  assign mismatch_count    = errors;
  assign chars_outstanding = owed;

  // Build the full formatted field of one number and queue its characters
  task automatic predict_text(input logic [63:0] value, input logic hex, input logic upper,
                              input logic signed [6:0] width_raw, input logic neg,
                              input logic [7:0] pad);
    string      digit_set;
    logic [63:0] rest;
    logic [7:0] body[$];
    text_char_t field[$];
    text_char_t one;
    int         width;
    int         total;
    bit         left_just;
    digit_set = upper ? "0123456789ABCDEF" : "0123456789abcdef";
    left_just = (width_raw < 0);
    width = left_just ? -int'(width_raw) : int'(width_raw);
    if (width > MAX_WIDTH) width = MAX_WIDTH;

    // digits, most significant ends up in front; zero gives one digit
    rest = value;
    do begin
      if (hex) begin
        body.push_front(digit_set[int'(rest[3:0])]);
        rest = rest >> 4;
      end else begin
        body.push_front(digit_set[int'(rest % 64'd10)]);
        rest = rest / 64'd10;
      end
    end while (rest != 0);
    if (neg) body.push_front(MINUS_CHAR);

    total = (width > body.size()) ? width : body.size();
    one.last = 1'b0;
    one.length = '0;

    // right-justified padding lands ahead of the sign, even with '0'
    if (!left_just) begin
      for (int i = body.size(); i < width; i++) begin
        one.ch = pad;
        field.push_back(one);
      end
    end
    foreach (body[i]) begin
      one.ch = body[i];
      field.push_back(one);
    end
    if (left_just) begin
      for (int i = body.size(); i < width; i++) begin
        one.ch = pad;
        field.push_back(one);
      end
    end
    field[field.size()-1].last = 1'b1;
    field[field.size()-1].length = 6'(total);
    foreach (field[i]) expected_text.push_back(field[i]);
  endtask

  // Outputs are checked before a new number is queued on the same edge
  always @(posedge clk) begin
    text_char_t got;
    text_char_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{ch: out_char, last: out_last, length: out_printed_length};
        if (expected_text.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected char %02h last %0b length %0d with nothing pending",
                     $realtime, got.ch, got.last, got.length);
        end else begin
          want = expected_text.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: expected char %02h last %0b length %0d, got char %02h last %0b length %0d",
                       $realtime, want.ch, want.last, want.length,
                       got.ch, got.last, got.length);
          end
        end
      end
      if (in_valid && in_ready)
        predict_text(in_value, in_hex_mode, in_upper_case, in_field_width, in_negative,
                     in_pad_char);
      owed = expected_text.size();
    end
  end

endmodule

FILE: sim/integer_text_formatter_tb.sv
// Testbench top for the integer text formatter: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module integer_text_formatter_tb;

  localparam int RANDOM_NUMBERS = 440;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 150;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_SPARSE
  } ready_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [63:0]       in_value = '0;
  logic              in_hex_mode = 1'b0;
  logic              in_upper_case = 1'b0;
  logic signed [6:0] in_field_width = '0;
  logic              in_negative = 1'b0;
  logic [7:0]        in_pad_char = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_char;
  logic              out_last;
  logic [5:0]        out_printed_length;

  int mismatches;
  int chars_owed;
  int burst_left = 0;
  int idle_cycles = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int ready_span = 0;

  integer_text_formatter dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_value, .in_hex_mode, .in_upper_case,
    .in_field_width, .in_negative, .in_pad_char,
    .out_valid, .out_ready, .out_char, .out_last, .out_printed_length
  );

  integer_text_formatter_checker text_check (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_value, .in_hex_mode, .in_upper_case,
    .in_field_width, .in_negative, .in_pad_char,
    .out_valid, .out_ready, .out_char, .out_last, .out_printed_length,
    .mismatch_count(mismatches),
    .chars_outstanding(chars_owed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: switches between stall patterns for spans of random length
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_span <= $urandom_range(16, 96);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      READY_MOSTLY: out_ready <= ($urandom_range(0, 9) != 0);
      default:      out_ready <= (ready_span[2:0] == 3'd0);
    endcase
  end

  // Watchdog: ends the run when no item moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL integer_text_formatter");
      $finish;
    end
  end

  // Offer one number; sender may idle between bursts of random length
  task automatic send_number(input logic [63:0] value, input logic hex, input logic upper,
                             input logic signed [6:0] width, input logic neg,
                             input logic [7:0] pad);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_value       <= value;
    in_hex_mode    <= hex;
    in_upper_case  <= upper;
    in_field_width <= width;
    in_negative    <= neg;
    in_pad_char    <= pad;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [63:0]       value;
    logic signed [6:0] width;
    logic [7:0]        pad;
    logic [63:0]       ten_power[20];

    ten_power[0] = 64'd1;
    for (int k = 1; k < 20; k++) ten_power[k] = ten_power[k-1] * 64'd10;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed numbers: field extremes and corner formats
    send_number(64'd0, 1'b0, 1'b0, 7'sd0, 1'b0, " ");                 // zero prints "0"
    send_number(64'd0, 1'b0, 1'b0, 7'sd0, 1'b1, " ");                 // "-0"
    send_number('1, 1'b0, 1'b0, 7'sd0, 1'b0, " ");                    // twenty digits
    send_number('1, 1'b1, 1'b0, 7'sd0, 1'b0, " ");
    send_number('1, 1'b1, 1'b1, 7'sd0, 1'b1, " ");
    send_number(64'hFEDC_BA98_7654_3210, 1'b1, 1'b1, -7'sd48, 1'b1, "*");
    send_number(64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 7'sd48, 1'b0, ".");
    send_number(64'd5, 1'b0, 1'b0, 7'sd5, 1'b1, "0");                 // zero pad before sign
    send_number(64'hA, 1'b1, 1'b1, 7'sd3, 1'b1, "0");
    send_number(64'd5, 1'b0, 1'b0, -7'sd5, 1'b1, "0");
    send_number(64'd1234, 1'b0, 1'b0, 7'sd63, 1'b0, " ");             // widths past the limit
    send_number(64'd1234, 1'b0, 1'b0, -7'sd64, 1'b1, "_");
    send_number(64'd77, 1'b1, 1'b0, -7'sd49, 1'b0, "#");
    send_number(64'd77, 1'b1, 1'b1, 7'sd49, 1'b1, "#");
    send_number(64'd42, 1'b0, 1'b0, 7'sd10, 1'b0, 8'h00);              // NUL pad
    send_number(64'd42, 1'b0, 1'b1, -7'sd10, 1'b0, 8'hFF);
    send_number(64'd123456789, 1'b0, 1'b1, 7'sd0, 1'b0, " ");         // case ignored in decimal
    send_number('1, 1'b0, 1'b0, 7'sd48, 1'b1, "0");
    send_number('1, 1'b0, 1'b0, -7'sd48, 1'b1, " ");
    send_number(64'd987654, 1'b0, 1'b0, 7'sd1, 1'b0, " ");            // width below digit count
    send_number(64'd987654, 1'b0, 1'b0, 7'sd7, 1'b1, " ");            // width equals text
    send_number(64'h8000_0000_0000_0000, 1'b1, 1'b0, -7'sd1, 1'b0, " ");
    send_number(ten_power[19], 1'b0, 1'b0, 7'sd21, 1'b1, "0");

    // Random numbers, mostly narrow fields
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      case ($urandom_range(0, 6))
        0: value = 64'($urandom_range(0, 9));
        1: value = {$urandom, $urandom};
        2: value = {$urandom, $urandom} >> $urandom_range(0, 63);
        3: value = ten_power[$urandom_range(0, 19)] - 64'($urandom_range(0, 1));
        4: value = 64'd1 << $urandom_range(0, 63);
        5: value = (~64'd0) >> $urandom_range(0, 63);
        default: value = 64'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0: width = 7'($urandom);
        1: width = 7'(-int'($urandom_range(0, 48)));
        2: width = 7'($urandom_range(0, 48));
        default: width = 7'(int'($urandom_range(0, 24)) - 12);
      endcase
      case ($urandom_range(0, 3))
        0: pad = " ";
        1: pad = "0";
        default: pad = 8'($urandom);
      endcase
      send_number(value, 1'($urandom), 1'($urandom), width, 1'($urandom), pad);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (chars_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && chars_owed == 0) begin
      $display("PASS integer_text_formatter");
    end else begin
      $display("FAIL integer_text_formatter");
    end
    $finish;
  end

endmodule
